// File: src/stt_pkg.sv
// Shared types and constants for the software timer task table.
// Used by stt_front, stt_back and software_timer_task_table; depends on nothing.
`default_nettype none

package stt_pkg;

	localparam int DEFAULT_NUM_SLOTS = 8;
	localparam int QUEUE_DEPTH       = 2;

	// Request codes as they arrive on the command port.
	localparam logic [2:0] REQ_REGISTER = 3'd0;
	localparam logic [2:0] REQ_DELAY    = 3'd1;
	localparam logic [2:0] REQ_DELETE   = 3'd2;
	localparam logic [2:0] REQ_TICK     = 3'd3;
	localparam logic [2:0] REQ_SCAN     = 3'd4;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [2:0] {
		OP_REGISTER,
		OP_DELAY,
		OP_DELETE,
		OP_TICK,
		OP_SCAN,
		OP_ERROR
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_WAIT  = 2'd1,
		MODE_READY = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  slot;
		logic [15:0] tick_count;
		logic [15:0] period_ticks;
		logic [7:0]  handler_id;
		logic [31:0] arg_word;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic [2:0]  slot_id;
		logic        dispatched;
		logic [7:0]  run_handler;
		logic [31:0] run_arg;
		logic        last;
	} result_t;

	// One classified item waiting between the front and the back.
	typedef struct packed {
		op_t         op;
		logic        in_range;
		logic [2:0]  slot;
		logic [15:0] tick_count;
		logic [15:0] period_ticks;
		logic [7:0]  handler_id;
		logic [31:0] arg_word;
	} qentry_t;

endpackage

`default_nettype wire

// File: src/stt_front.sv
// Front end of the timer table: decodes each accepted item and keeps it in a short queue.
// Depends on stt_pkg.
`default_nettype none

module stt_front #(
	parameter int NUM_SLOTS = stt_pkg::DEFAULT_NUM_SLOTS
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  stt_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            head_valid,
	output stt_pkg::qentry_t head,
	input  wire             pop
);
	import stt_pkg::*;

	localparam int QDEPTH = QUEUE_DEPTH;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	qentry_t           qe_q [QDEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  cnt_q;
	qentry_t           entry;
	logic              push;
	logic              do_pop;

	always_comb begin
		entry              = '0;
		entry.slot         = cmd.slot;
		entry.tick_count   = cmd.tick_count;
		entry.period_ticks = cmd.period_ticks;
		entry.handler_id   = cmd.handler_id;
		entry.arg_word     = cmd.arg_word;
		entry.in_range     = ({29'd0, cmd.slot} < 32'(NUM_SLOTS));
		unique case (cmd.req_type)
			REQ_REGISTER: entry.op = OP_REGISTER;
			REQ_DELAY:    entry.op = OP_DELAY;
			REQ_DELETE:   entry.op = OP_DELETE;
			REQ_TICK:     entry.op = OP_TICK;
			REQ_SCAN:     entry.op = OP_SCAN;
			default:      entry.op = OP_ERROR;
		endcase
	end

	assign busy       = (cnt_q == CNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = qe_q[rptr_q];
	assign push       = start && !busy;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			qe_q[wptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/stt_back.sv
// Back end of the timer table: slot store and the sequencer that carries out each item.
// Depends on stt_pkg.
`default_nettype none

module stt_back #(
	parameter int NUM_SLOTS = stt_pkg::DEFAULT_NUM_SLOTS
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              head_valid,
	input  stt_pkg::qentry_t head,
	output logic             pop,
	output logic             result_strobe,
	output stt_pkg::result_t result
);
	import stt_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		B_IDLE,
		B_REG,
		B_TICK,
		B_SCAN,
		B_DONE
	} bstate_t;

	typedef struct packed {
		logic [15:0] period;
		logic [7:0]  handler;
		logic [31:0] arg;
	} desc_t;

	typedef struct packed {
		logic [2:0]  slot_id;
		logic [7:0]  handler;
		logic [31:0] arg;
	} pend_t;

	// Slot store: modes in flip-flops, the rest in memories.
	mode_t             mode_q [NUM_SLOTS];
	logic [15:0]       ticks_mem [NUM_SLOTS];
	desc_t             desc_mem [NUM_SLOTS];
	logic [15:0]       rd_ticks_q;
	desc_t             rd_desc_q;

	bstate_t           state_q;
	logic [IDX_W-1:0]  idx_q;
	logic              iss_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	pend_t             pend_q;
	logic              pend_valid_q;
	result_t           res_q;
	logic              strobe_q;

	logic [IDX_W-1:0]  slot_idx;
	logic              slot_ok;
	logic [15:0]       next_ticks;
	logic              found;
	logic              oneshot;
	logic              scan_end;
	logic              pass_end;

	logic              tk_we;
	logic [IDX_W-1:0]  tk_addr;
	logic [15:0]       tk_data;
	logic              ds_we;
	logic              md_we;
	logic [IDX_W-1:0]  md_idx;
	mode_t             md_val;
	logic              emit_v;
	result_t           emit_r;

	assign slot_idx   = IDX_W'(head.slot);
	assign slot_ok    = head.in_range && (mode_q[slot_idx] != MODE_IDLE);
	assign next_ticks = rd_ticks_q - {15'd0, (rd_ticks_q != 16'd0)};
	assign found      = v_s1 && (mode_q[idx_s1] == MODE_READY) && (rd_desc_q.handler != 8'd0);
	assign oneshot    = (rd_desc_q.period == 16'd0);
	assign pass_end   = v_s1 && (idx_s1 == LAST_IDX);
	assign scan_end   = (found && oneshot) || pass_end;

	always_comb begin
		emit_v  = 1'b0;
		emit_r  = '0;
		pop     = 1'b0;
		tk_we   = 1'b0;
		tk_addr = idx_s1;
		tk_data = next_ticks;
		ds_we   = 1'b0;
		md_we   = 1'b0;
		md_idx  = idx_s1;
		md_val  = MODE_IDLE;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					unique case (head.op) inside
						OP_DELAY, OP_DELETE: begin
							emit_v         = 1'b1;
							pop            = 1'b1;
							emit_r.last    = 1'b1;
							emit_r.slot_id = head.slot;
							if (slot_ok) begin
								md_we  = 1'b1;
								md_idx = slot_idx;
								if (head.op == OP_DELAY) begin
									tk_we   = 1'b1;
									tk_addr = slot_idx;
									tk_data = head.tick_count;
									md_val  = MODE_WAIT;
								end
							end else begin
								emit_r.status = STATUS_ERR;
							end
						end
						OP_ERROR: begin
							emit_v        = 1'b1;
							pop           = 1'b1;
							emit_r.last   = 1'b1;
							emit_r.status = STATUS_ERR;
						end
						default: begin
						end
					endcase
				end
			end
			B_REG: begin
				if (mode_q[idx_q] == MODE_IDLE) begin
					ds_we          = 1'b1;
					tk_we          = 1'b1;
					tk_addr        = idx_q;
					tk_data        = head.tick_count;
					md_we          = 1'b1;
					md_idx         = idx_q;
					md_val         = (head.tick_count != 16'd0) ? MODE_WAIT : MODE_READY;
					emit_v         = 1'b1;
					pop            = 1'b1;
					emit_r.slot_id = 3'(idx_q);
					emit_r.last    = 1'b1;
				end else if (idx_q == LAST_IDX) begin
					emit_v        = 1'b1;
					pop           = 1'b1;
					emit_r.status = STATUS_ERR;
					emit_r.last   = 1'b1;
				end
			end
			B_TICK: begin
				if (v_s1 && (mode_q[idx_s1] == MODE_WAIT)) begin
					tk_we = 1'b1;
					if (next_ticks == 16'd0) begin
						md_we  = 1'b1;
						md_val = MODE_READY;
					end
				end
				if (pass_end) begin
					emit_v      = 1'b1;
					pop         = 1'b1;
					emit_r.last = 1'b1;
				end
			end
			B_SCAN: begin
				if (found) begin
					md_we = 1'b1;
					if (!oneshot) begin
						tk_we   = 1'b1;
						tk_data = rd_desc_q.period;
						md_val  = MODE_WAIT;
					end
					// An earlier dispatch is known not to be the final one now.
					if (pend_valid_q) begin
						emit_v             = 1'b1;
						emit_r.slot_id     = pend_q.slot_id;
						emit_r.dispatched  = 1'b1;
						emit_r.run_handler = pend_q.handler;
						emit_r.run_arg     = pend_q.arg;
					end
				end
			end
			B_DONE: begin
				emit_v      = 1'b1;
				pop         = 1'b1;
				emit_r.last = 1'b1;
				if (pend_valid_q) begin
					emit_r.slot_id     = pend_q.slot_id;
					emit_r.dispatched  = 1'b1;
					emit_r.run_handler = pend_q.handler;
					emit_r.run_arg     = pend_q.arg;
				end
			end
			default: begin
			end
		endcase
	end

	// Slot memories; read data is registered and used in the following cycle.
	always_ff @(posedge clk) begin
		if (tk_we) begin
			ticks_mem[tk_addr] <= tk_data;
		end
		if (ds_we) begin
			desc_mem[idx_q] <= '{period: head.period_ticks, handler: head.handler_id,
				arg: head.arg_word};
		end
		rd_ticks_q <= ticks_mem[idx_q];
		rd_desc_q  <= desc_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				mode_q[i] <= MODE_IDLE;
			end
		end else if (md_we) begin
			mode_q[md_idx] <= md_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			idx_q        <= '0;
			iss_q        <= 1'b0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			res_q        <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= emit_v;
			if (emit_v) begin
				res_q <= emit_r;
			end
			unique case (state_q)
				B_IDLE: begin
					if (head_valid) begin
						unique case (head.op)
							OP_REGISTER: begin
								idx_q   <= '0;
								state_q <= B_REG;
							end
							OP_TICK: begin
								idx_q   <= '0;
								iss_q   <= 1'b1;
								v_s1    <= 1'b0;
								state_q <= B_TICK;
							end
							OP_SCAN: begin
								idx_q        <= '0;
								iss_q        <= 1'b1;
								v_s1         <= 1'b0;
								pend_valid_q <= 1'b0;
								state_q      <= B_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				B_REG: begin
					if (pop) begin
						state_q <= B_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				B_TICK, B_SCAN: begin
					if ((state_q == B_SCAN) && scan_end) begin
						// A freed one-shot slot or the end of the table closes the scan;
						// a read still in flight is dropped.
						iss_q   <= 1'b0;
						v_s1    <= 1'b0;
						state_q <= B_DONE;
					end else begin
						v_s1   <= iss_q;
						idx_s1 <= idx_q;
						if (iss_q) begin
							if (idx_q == LAST_IDX) begin
								iss_q <= 1'b0;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						if ((state_q == B_TICK) && pass_end) begin
							state_q <= B_IDLE;
						end
					end
					if ((state_q == B_SCAN) && found) begin
						pend_q       <= '{slot_id: 3'(idx_s1), handler: rd_desc_q.handler,
							arg: rd_desc_q.arg};
						pend_valid_q <= 1'b1;
					end
				end
				B_DONE: begin
					pend_valid_q <= 1'b0;
					state_q      <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign result        = res_q;

endmodule

`default_nettype wire

// File: src/software_timer_task_table.sv
// Top level of the software timer task table: front end, queue and slot sequencer.
// Depends on stt_pkg, stt_front and stt_back.
`default_nettype none

// A table of NUM_SLOTS timer slots driven by register, delay, delete, tick and
// dispatch scan items.
// Command channel: an item on cmd is accepted at a rising edge where start is
// high and busy is low. Accepted items are decoded and placed in a two-entry
// queue, so the source may hand over the next item while the back end is still
// working; busy rises only when the queue is full.
// Result channel: every result sits on result for exactly one cycle with
// result_strobe high. The receiver cannot stall; results are never held back.
// Each item gives one result, except a dispatch scan that dispatches slots,
// which gives one per dispatched slot; every item's final result carries last.
// Timing: the back end takes one item at a time from the queue. Delay, delete
// and unknown requests are answered straight from the idle state. Register
// passes through the idle state, then searches the slots in order, one per
// cycle, up to the lowest free slot, or to the last slot when the table is
// full. Tick walks every slot of the tick-count memory in order. A dispatch
// scan walks the slots the same way and stops early at a freed one-shot slot.
// When the queue was empty, an accepted item passes through the queue register
// and the result register before its first result appears.
// Reset: arst_n clears every slot to idle and empties the queue; the data
// stores of a slot are written by register before the slot is ever used.
module software_timer_task_table #(
	parameter int NUM_SLOTS = stt_pkg::DEFAULT_NUM_SLOTS
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  stt_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             result_strobe,
	output stt_pkg::result_t result
);
	import stt_pkg::*;

	logic    head_valid;
	qentry_t head;
	logic    pop;

	stt_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	stt_back #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_strobe(result_strobe),
		.result       (result)
	);

	// An accepted item is waiting for the back end in the next cycle.
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> head_valid)
		else $error("accepted item missing from queue");

	// Only a dispatch result can be followed by more results of the same item.
	a_nondispatch_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.dispatched) |-> result.last)
		else $error("non-dispatch result not marked last");

	// A dispatched slot always has a handler and never reports an error.
	a_dispatch_handler: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.dispatched) |->
			(result.run_handler != 8'd0) && (result.status == STATUS_OK))
		else $error("dispatch without handler or with error status");

	// The queue is popped only while it holds an item.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for software_timer_task_table.
// Depends on stt_pkg and the software_timer_task_table RTL; needs no files or arguments.
`default_nettype none

module tb;
	import stt_pkg::*;

	localparam int NUM_SLOTS = DEFAULT_NUM_SLOTS;
	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 6;
	// A dispatch scan is the slowest item; allow well over its cycle count.
	localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    result_strobe;
	result_t result;

	// Our own copy of the timer table, updated as each item is accepted.
	mode_t       timer_mode[NUM_SLOTS];
	logic [15:0] timer_ticks[NUM_SLOTS];
	logic [15:0] timer_period[NUM_SLOTS];
	logic [7:0]  timer_handler[NUM_SLOTS];
	logic [31:0] timer_arg[NUM_SLOTS];

	// Results the table still owes us, oldest first.
	result_t pending_results[$];

	int error_count = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int dispatch_count = 0;
	int full_count = 0;
	int idle_pct = 0;

	software_timer_task_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// A plain one-result outcome: everything but status and slot is zero, last is set.
	function automatic result_t single_result(logic status, logic [2:0] sid);
		result_t r;
		r = '0;
		r.status = status;
		r.slot_id = sid;
		r.last = 1'b1;
		return r;
	endfunction

	// Works out the results of one accepted item and advances the table copy.
	function automatic void predict_timer_item(cmd_t c);
		result_t r;
		int n;
		bit found;
		bit stop;
		n = 0;
		found = 1'b0;
		stop = 1'b0;
		case (c.req_type)
			REQ_REGISTER: begin
				// The lowest idle slot takes the timer; zero ticks means it is ready at once.
				for (int i = 0; i < NUM_SLOTS && !found; i++) begin
					if (timer_mode[i] == MODE_IDLE) begin
						timer_ticks[i] = c.tick_count;
						timer_period[i] = c.period_ticks;
						timer_handler[i] = c.handler_id;
						timer_arg[i] = c.arg_word;
						timer_mode[i] = (c.tick_count != 16'd0) ? MODE_WAIT : MODE_READY;
						pending_results.push_back(single_result(STATUS_OK, 3'(i)));
						found = 1'b1;
					end
				end
				if (!found) begin
					pending_results.push_back(single_result(STATUS_ERR, 3'd0));
					full_count++;
				end
			end
			REQ_DELAY, REQ_DELETE: begin
				if (timer_mode[c.slot] == MODE_IDLE) begin
					pending_results.push_back(single_result(STATUS_ERR, c.slot));
				end else begin
					if (c.req_type == REQ_DELAY) begin
						timer_ticks[c.slot] = c.tick_count;
						timer_mode[c.slot] = MODE_WAIT;
					end else begin
						timer_mode[c.slot] = MODE_IDLE;
					end
					pending_results.push_back(single_result(STATUS_OK, c.slot));
				end
			end
			REQ_TICK: begin
				// A waiting slot with zero ticks (from a zero delay) turns ready without wrapping.
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (timer_mode[i] == MODE_WAIT) begin
						if (timer_ticks[i] != 16'd0)
							timer_ticks[i] = timer_ticks[i] - 16'd1;
						if (timer_ticks[i] == 16'd0)
							timer_mode[i] = MODE_READY;
					end
				end
				pending_results.push_back(single_result(STATUS_OK, 3'd0));
			end
			REQ_SCAN: begin
				// Ready slots without a handler are skipped and stay ready. A one-shot
				// slot is freed and stops the scan; a periodic one reloads and waits.
				for (int i = 0; i < NUM_SLOTS && !stop; i++) begin
					if (timer_mode[i] == MODE_READY && timer_handler[i] != 8'd0) begin
						r = '0;
						r.status = STATUS_OK;
						r.slot_id = 3'(i);
						r.dispatched = 1'b1;
						r.run_handler = timer_handler[i];
						r.run_arg = timer_arg[i];
						pending_results.push_back(r);
						n++;
						if (timer_period[i] != 16'd0) begin
							timer_ticks[i] = timer_period[i];
							timer_mode[i] = MODE_WAIT;
						end else begin
							timer_mode[i] = MODE_IDLE;
							stop = 1'b1;
						end
					end
				end
				if (n == 0)
					pending_results.push_back(single_result(STATUS_OK, 3'd0));
				else
					pending_results[pending_results.size() - 1].last = 1'b1;
			end
			default: begin
				pending_results.push_back(single_result(STATUS_ERR, 3'd0));
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// One process both checks results and records accepted items, so a result and an
	// acceptance at the same edge are always handled in the same order. Results are
	// checked first: an item accepted at this edge cannot have produced one yet.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_strobe) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, result);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("slot_id", 32'(want.slot_id), 32'(result.slot_id));
					check_field("dispatched", 32'(want.dispatched), 32'(result.dispatched));
					check_field("run_handler", 32'(want.run_handler), 32'(result.run_handler));
					check_field("run_arg", want.run_arg, result.run_arg);
					check_field("last", 32'(want.last), 32'(result.last));
					results_checked++;
					if (result.dispatched === 1'b1)
						dispatch_count++;
				end
			end
			if (start && !busy) begin
				predict_timer_item(cmd);
				items_accepted++;
			end
		end
	end

	function automatic cmd_t make_cmd(logic [2:0] req, logic [2:0] slot, logic [15:0] ticks,
		logic [15:0] period, logic [7:0] hnd, logic [31:0] arg);
		cmd_t c;
		c.req_type = req;
		c.slot = slot;
		c.tick_count = ticks;
		c.period_ticks = period;
		c.handler_id = hnd;
		c.arg_word = arg;
		return c;
	endfunction

	// Presents one item and returns at the edge where it is taken, or after an idle spell.
	// Start stays high unless the sender idles, so back-to-back items keep it up throughout.
	task automatic send_item(cmd_t c);
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Holds the sender off until every owed result has come back. Always waits at
	// least one edge so start is never lowered and raised in the same step.
	task automatic wait_until_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Mostly well-formed traffic: small tick counts and periods so that timers
	// actually expire and get dispatched, with the occasional full-range value,
	// missing handler and unknown request code mixed in.
	function automatic cmd_t random_item();
		cmd_t c;
		int pick;
		c.slot = 3'($urandom_range(7));
		c.tick_count = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
		c.period_ticks = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
		c.handler_id = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		c.arg_word = $urandom;
		pick = $urandom_range(99);
		if (pick < 22)
			c.req_type = REQ_REGISTER;
		else if (pick < 32)
			c.req_type = REQ_DELAY;
		else if (pick < 42)
			c.req_type = REQ_DELETE;
		else if (pick < 70)
			c.req_type = REQ_TICK;
		else if (pick < 97)
			c.req_type = REQ_SCAN;
		else
			c.req_type = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
		return c;
	endfunction

	// An empty table: a scan with nothing to do, unknown request codes, and delay
	// and delete aimed at slots that are not in use.
	task automatic test_empty_table();
		send_item(make_cmd(REQ_SCAN, 3'd0, 16'd0, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_UNKNOWN_LO, 3'd0, 16'd0, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_UNKNOWN_HI, 3'd7, 16'hffff, 16'hffff, 8'hff, 32'hffffffff));
		send_item(make_cmd(REQ_DELAY, 3'd7, 16'hffff, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_DELETE, 3'd0, 16'd0, 16'd0, 8'd0, 32'd0));
		wait_until_drained();
	endtask

	// Fill every slot with field extremes, then register once more into a full table.
	task automatic test_fill_table();
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd0, 16'd0, 8'hff, 32'hffffffff));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd0, 16'd0, 8'd0, 32'h5a5a5a5a));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd1, 16'd2, 8'd1, 32'd0));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'hffff, 16'hffff, 8'h80, 32'h12345678));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd0, 16'd1, 8'h11, 32'h80000001));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd0, 16'd1, 8'h22, 32'h7fffffff));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd0, 16'd1, 8'h33, 32'hdeadbeef));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd0, 16'd0, 8'h7f, 32'h0000ffff));
		send_item(make_cmd(REQ_REGISTER, 3'd0, 16'd5, 16'd5, 8'h44, 32'h44444444));
		wait_until_drained();
	endtask

	// The first scan hits the one-shot in slot 0 and stops there. The second skips
	// the ready slot without a handler, dispatches the periodic slots and ends on
	// the one-shot in the last slot.
	task automatic test_dispatch_rules();
		send_item(make_cmd(REQ_SCAN, 3'd0, 16'd0, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_SCAN, 3'd7, 16'hffff, 16'hffff, 8'hff, 32'hffffffff));
		wait_until_drained();
	endtask

	// A zero delay turns ready on the next tick; delete frees a slot; a delay to a
	// freed slot is refused; the final scan sees every reloaded slot come due.
	task automatic test_delay_delete_tick();
		send_item(make_cmd(REQ_DELAY, 3'd3, 16'd0, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_DELETE, 3'd1, 16'd0, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_DELAY, 3'd0, 16'd3, 16'd0, 8'd0, 32'd0));
		send_item(make_cmd(REQ_SCAN, 3'd0, 16'd0, 16'd0, 8'd0, 32'd0));
		wait_until_drained();
	endtask

	// A batch of random items at the given sender idle rate, drained at the end.
	task automatic test_random_traffic(int count, int pct);
		idle_pct = pct;
		repeat (count)
			send_item(random_item());
		wait_until_drained();
	endtask

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++)
			timer_mode[i] = MODE_IDLE;
		idle_pct = 28;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_table();
		test_dispatch_rules();
		test_delay_delete_tick();

		// The sender idles now and then, then often, then never.
		test_random_traffic(140, 28);
		test_random_traffic(140, 81);
		test_random_traffic(140, 0);

		// Let any stray result show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items covering register, delay, delete, tick, scan and bad codes.",
			items_accepted);
		$display("Checked %0d results: %0d handler dispatches, %0d registers into a full table.",
			results_checked, dispatch_count, full_count);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run of this stimulus.
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
src/stt_pkg.sv
src/stt_front.sv
src/stt_back.sv
src/software_timer_task_table.sv
verif/tb.sv
